// File: rtl/mht_pkg.sv
// ----------------------------------------------------------------------------
// mht_pkg: shared types and codes of the multilevel hash table
// Operation codes, result status codes and the state encoding of the
// table sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package mht_pkg;

    // Field widths of the request and result streams.
    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int HASH_W  = 32;
    localparam int VALUE_W = 64;
    localparam int STAT_W  = 2;

    // Operation codes carried on the request tuser.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Status codes carried on the result tuser.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_IDX,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/multilevel_hash_table.sv
// ----------------------------------------------------------------------------
// multilevel_hash_table: key-value table built as levels of slot arrays
// Insert-if-absent, update-existing and lookup over LEVELS levels of SLOTS
// slots, probed one level per cycle from a single synchronous memory.
// ----------------------------------------------------------------------------
// The table keeps LEVELS levels of SLOTS slots in one single-port memory whose
// words hold a used flag, the key (low KEY_BITS bits) and a 64-bit value. The
// slot of a request is key_hash modulo SLOTS; the probe visits that slot in
// level 0, level 1 and so on, and stops at the first unused slot, at a slot
// holding the same key, or after the last level. After reset the block sweeps
// the memory once to mark every slot unused, one entry per cycle, and takes no
// request until the sweep is done. One request is worked at a time: the states
// MUL1, MUL2 and IDX reduce the hash to a slot index (a reciprocal multiply, a
// multiply back and one corrective subtract), READ issues the first read, CHECK
// then probes the levels one per cycle on the memory read port, and DONE hands
// the result to the output register once that register is free. A request that
// probes k levels (1 to LEVELS) occupies the block until its result is handed
// on, so the memory read port and the hash reduction set the rate. A finished
// result waits in the output register while the next request is already
// taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_hash_table #(
    parameter int SLOTS    = 256,
    parameter int LEVELS   = 4,
    parameter int KEY_BITS = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // Request stream.
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // tdata from bit 0 up: key[63:0], key_hash[95:64], write_value[159:96].
    input  wire logic [159:0] s_axis_tdata,
    // tuser: op[1:0].
    input  wire logic [1:0]   s_axis_tuser,

    // Result stream.
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: read_value[63:0].
    output      logic [63:0]  m_axis_tdata,
    // tuser: status[1:0].
    output      logic [1:0]   m_axis_tuser
);

    localparam int DEPTH  = SLOTS * LEVELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int WORD_W = 1 + KEY_BITS + mht_pkg::VALUE_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0]  LAST_LVL  = LVL_W'(LEVELS - 1);
    localparam logic [ADDR_W:0]   SLOT_STEP = (ADDR_W + 1)'(SLOTS);

    // floor(2^32 / SLOTS); the estimated quotient is then at most one short.
    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / SLOTS;
    localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
    localparam logic [31:0] SLOTS_32   = 32'(SLOTS);

    // Table memory: {used, key, value}.
    logic [WORD_W-1:0] mem [DEPTH];

    mht_pkg::t_state r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic              r_out_valid, n_out_valid;

    logic [mht_pkg::OP_W-1:0]    r_op, n_op;
    logic [KEY_BITS-1:0]         r_key, n_key;
    logic [mht_pkg::HASH_W-1:0]  r_hash, n_hash;
    logic [mht_pkg::VALUE_W-1:0] r_wv, n_wv;
    logic [31:0]                 r_qest, n_qest;
    logic [31:0]                 r_qd, n_qd;
    logic [mht_pkg::STAT_W-1:0]  r_res_status, n_res_status;
    logic [mht_pkg::VALUE_W-1:0] r_res_rv, n_res_rv;
    logic [mht_pkg::STAT_W-1:0]  r_out_status, n_out_status;
    logic [mht_pkg::VALUE_W-1:0] r_out_rv, n_out_rv;
    logic [WORD_W-1:0]           r_rd_word;

    logic                        mem_we;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_addr;
    logic [WORD_W-1:0]           mem_wdata;

    logic [63:0]                 prod;
    logic [48:0]                 qd_full;
    logic [31:0]                 rem;
    logic [31:0]                 slot_red;
    logic [ADDR_W-1:0]           next_addr;
    logic                        rd_used;
    logic [KEY_BITS-1:0]         rd_key;
    logic [mht_pkg::VALUE_W-1:0] rd_value;
    logic                        hit_free;
    logic                        hit_match;
    logic                        accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Hash reduction: q ~ hash * RECIP >> 32, remainder below 2*SLOTS.
    assign prod     = {32'b0, r_hash} * {32'b0, RECIP};
    assign qd_full  = {17'b0, r_qest} * {17'b0, SLOTS_32};
    assign rem      = r_hash - r_qd;
    assign slot_red = (rem >= SLOTS_32) ? (rem - SLOTS_32) : rem;

    assign next_addr = ADDR_W'({1'b0, r_addr} + SLOT_STEP);

    assign rd_used   = r_rd_word[WORD_W-1];
    assign rd_key    = r_rd_word[mht_pkg::VALUE_W +: KEY_BITS];
    assign rd_value  = r_rd_word[mht_pkg::VALUE_W-1:0];
    assign hit_free  = !rd_used;
    assign hit_match = rd_used && (rd_key == r_key);

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_lvl        = r_lvl;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_key        = r_key;
        n_hash       = r_hash;
        n_wv         = r_wv;
        n_qest       = r_qest;
        n_qd         = r_qd;
        n_res_status = r_res_status;
        n_res_rv     = r_res_rv;
        n_out_status = r_out_status;
        n_out_rv     = r_out_rv;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = r_addr;
        mem_wdata    = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mht_pkg::ST_CLEAR: begin
                // Write an unused word to every entry, one per cycle.
                mem_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = mht_pkg::ST_IDLE;
                end else begin
                    n_addr = ADDR_W'({1'b0, r_addr} + (ADDR_W + 1)'(1));
                end
            end
            mht_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op    = s_axis_tuser;
                    n_key   = s_axis_tdata[KEY_BITS-1:0];
                    n_hash  = s_axis_tdata[95:64];
                    n_wv    = s_axis_tdata[159:96];
                    n_state = mht_pkg::ST_MUL1;
                end
            end
            mht_pkg::ST_MUL1: begin
                n_qest  = prod[63:32];
                n_state = mht_pkg::ST_MUL2;
            end
            mht_pkg::ST_MUL2: begin
                n_qd    = qd_full[31:0];
                n_state = mht_pkg::ST_IDX;
            end
            mht_pkg::ST_IDX: begin
                n_addr  = ADDR_W'(slot_red);
                n_lvl   = '0;
                n_state = mht_pkg::ST_READ;
            end
            mht_pkg::ST_READ: begin
                mem_re  = 1'b1;
                n_state = mht_pkg::ST_CHECK;
            end
            mht_pkg::ST_CHECK: begin
                if (hit_free || hit_match || (r_lvl == LAST_LVL)) begin
                    n_res_status = mht_pkg::STAT_NOT_FOUND;
                    n_res_rv     = '0;
                    case (r_op)
                        mht_pkg::OP_INSERT: begin
                            if (hit_match) begin
                                n_res_status = mht_pkg::STAT_PRESENT;
                            end else if (hit_free) begin
                                mem_we       = 1'b1;
                                mem_wdata    = {1'b1, r_key, r_wv};
                                n_res_status = mht_pkg::STAT_OK;
                            end else begin
                                n_res_status = mht_pkg::STAT_FULL;
                            end
                        end
                        mht_pkg::OP_UPDATE: begin
                            if (hit_match) begin
                                mem_we       = 1'b1;
                                mem_wdata    = {1'b1, r_key, r_wv};
                                n_res_status = mht_pkg::STAT_OK;
                            end
                        end
                        mht_pkg::OP_LOOKUP: begin
                            if (hit_match) begin
                                n_res_rv     = rd_value;
                                n_res_status = mht_pkg::STAT_OK;
                            end
                        end
                        default: begin
                            n_res_status = mht_pkg::STAT_NOT_FOUND;
                        end
                    endcase
                    n_state = mht_pkg::ST_DONE;
                end else begin
                    // Same slot, next level.
                    n_addr   = next_addr;
                    n_lvl    = LVL_W'(r_lvl + 1'b1);
                    mem_re   = 1'b1;
                    mem_addr = next_addr;
                end
            end
            mht_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_rv     = r_res_rv;
                    n_state      = mht_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mht_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mht_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_hash       <= n_hash;
        r_wv         <= n_wv;
        r_qest       <= n_qest;
        r_qd         <= n_qd;
        r_res_status <= n_res_status;
        r_res_rv     <= n_res_rv;
        r_out_status <= n_out_status;
        r_out_rv     <= n_out_rv;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_word <= mem[mem_addr];
        end
    end

    assign s_axis_tready = (r_state == mht_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_rv;
    assign m_axis_tuser  = r_out_status;

    // The reduced slot index must land inside one level.
    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mht_pkg::ST_READ) |-> ({1'b0, r_addr} < SLOT_STEP))
        else $error("slot index out of range");

    // The probe never runs past the last level.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mht_pkg::ST_CHECK) |-> (r_lvl <= LAST_LVL))
        else $error("probe ran past the last level");

    // A table write during a probe ends that probe.
    a_write_ends_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == mht_pkg::ST_CHECK)) |=> (r_state == mht_pkg::ST_DONE))
        else $error("table written without finishing the request");

    // Only a successful lookup returns a nonzero value.
    a_value_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata != '0)) |-> (m_axis_tuser == mht_pkg::STAT_OK))
        else $error("value returned with a failing status");

endmodule

`default_nettype wire
